// File: sv/pfx_pkg.sv
package pfx_pkg;

	localparam int OUT_W    = 8;
	localparam int STATUS_W = 3;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_UNDERFLOW = 3'd1;
	localparam status_t ST_DIVZERO   = 3'd2;
	localparam status_t ST_OVERFLOW  = 3'd3;
	localparam status_t ST_EMPTY     = 3'd4;

	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;
	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;

endpackage

// File: sv/postfix_expression_evaluator_core.sv
// postfix evaluator: one symbol per transaction, one result per expression end
// digits are pushed in DECODE; operators read both operands, + - and unknown ones end
// in OP, '*' and '/' loop in MUL or DIV (shift-add and restoring divide share one
// adder, one bit a cycle); a last symbol then loads its result in FIN, waiting while the
// previous result is held; a symbol at a time; the stack ram port is read once a cycle
// reset clears stack count, sticky error and handshake state; stack ram is not cleared
module postfix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           symbol,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pfx_pkg::OUT_W-1:0]     value,
	output logic [pfx_pkg::STATUS_W-1:0]         status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = $clog2(VALUE_WIDTH);
	localparam int VW = VALUE_WIDTH;

	typedef enum logic [3:0] {
		IDLE, DECODE, RD_B, RD_A, OP, MUL, ABS_A, ABS_B, DIV, FIX, PUSH, CHECK_END, FIN
	} state_t;

	state_t            state_q;
	logic [7:0]        sym_q;
	logic              last_q;
	logic [CW-1:0]     count_q;
	pfx_pkg::status_t  err_q;
	logic [VW-1:0]     a_q, b_q, acc_q, mq_q, mcand_q;
	logic [VW:0]       rem_q;
	logic              neg_q;
	logic [SW-1:0]     step_q;
	logic              out_valid_q;
	logic [pfx_pkg::OUT_W-1:0] out_value_q;
	pfx_pkg::status_t  out_status_q;

	// shared adder / subtractor
	logic [VW:0]   alu_x, alu_y;
	logic          alu_sub;
	logic [VW+1:0] alu_sum;
	logic          alu_carry;

	// stack ram port
	logic          st_we, st_re;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [VW-1:0] st_wdata, st_rdata;

	logic          is_digit;
	logic          out_load;
	logic [VW:0]   div_x;
	logic signed [VW-1:0] top_s;

	assign is_digit = (sym_q >= pfx_pkg::SYM_ZERO) && (sym_q <= pfx_pkg::SYM_NINE);
	assign out_load = (state_q == FIN) && (!out_valid_q || out_ready);
	assign div_x    = {rem_q[VW-1:0], mq_q[VW-1]};
	assign top_s    = (count_q != '0) ? st_rdata : '0;

	always_comb begin
		alu_x   = {1'b0, a_q};
		alu_y   = {1'b0, b_q};
		alu_sub = 1'b0;
		unique case (state_q)
			OP: begin
				alu_sub = (sym_q == pfx_pkg::SYM_SUB);
			end
			MUL: begin
				alu_x = {1'b0, acc_q};
				alu_y = {1'b0, mcand_q};
			end
			ABS_A: begin
				alu_x   = '0;
				alu_y   = {1'b0, a_q};
				alu_sub = 1'b1;
			end
			ABS_B: begin
				alu_x   = '0;
				alu_sub = 1'b1;
			end
			DIV: begin
				alu_x   = div_x;
				alu_sub = 1'b1;
			end
			FIX: begin
				alu_x   = '0;
				alu_y   = {1'b0, mq_q};
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
		alu_sum   = {1'b0, alu_x} + {1'b0, alu_y ^ {(VW+1){alu_sub}}} + (VW+2)'(alu_sub);
		alu_carry = alu_sum[VW+1];
	end

	always_comb begin
		st_we    = 1'b0;
		st_waddr = count_q[AW-1:0];
		st_wdata = VW'(sym_q[3:0]);
		st_re    = 1'b0;
		st_raddr = AW'(count_q - CW'(1));
		unique case (state_q)
			DECODE: begin
				st_we = is_digit && (count_q != CW'(STACK_DEPTH));
				st_re = !is_digit && (count_q >= CW'(2));
			end
			RD_B: begin
				st_re    = 1'b1;
				st_raddr = AW'(count_q - CW'(2));
			end
			OP: begin
				st_waddr = AW'(count_q - CW'(2));
				st_wdata = alu_sum[VW-1:0];
				st_we    = (sym_q == pfx_pkg::SYM_ADD) || (sym_q == pfx_pkg::SYM_SUB);
			end
			PUSH: begin
				st_we    = 1'b1;
				st_waddr = AW'(count_q - CW'(2));
				st_wdata = acc_q;
			end
			CHECK_END: begin
				st_re = last_q && (count_q != '0);
			end
			default: begin
			end
		endcase
	end

	pfx_stack #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (VW)
	) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			err_q       <= pfx_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						sym_q   <= symbol;
						last_q  <= last;
						state_q <= DECODE;
					end
				end
				DECODE: begin
					if (is_digit) begin
						if (count_q == CW'(STACK_DEPTH)) begin
							if (err_q == pfx_pkg::ST_OK) err_q <= pfx_pkg::ST_OVERFLOW;
						end else begin
							count_q <= count_q + CW'(1);
						end
						state_q <= CHECK_END;
					end else if (count_q < CW'(2)) begin
						if (err_q == pfx_pkg::ST_OK) err_q <= pfx_pkg::ST_UNDERFLOW;
						state_q <= CHECK_END;
					end else begin
						state_q <= RD_B;
					end
				end
				RD_B: begin
					b_q     <= st_rdata;
					state_q <= RD_A;
				end
				RD_A: begin
					a_q     <= st_rdata;
					state_q <= OP;
				end
				OP: begin
					unique case (sym_q)
						pfx_pkg::SYM_ADD, pfx_pkg::SYM_SUB: begin
							count_q <= count_q - CW'(1);
							state_q <= CHECK_END;
						end
						pfx_pkg::SYM_MUL: begin
							acc_q   <= '0;
							mcand_q <= a_q;
							mq_q    <= b_q;
							step_q  <= '0;
							state_q <= MUL;
						end
						pfx_pkg::SYM_DIV: begin
							if (b_q == '0) begin
								if (err_q == pfx_pkg::ST_OK) err_q <= pfx_pkg::ST_DIVZERO;
								acc_q   <= '0;
								state_q <= PUSH;
							end else begin
								state_q <= ABS_A;
							end
						end
						default: begin
							// unknown operator just drops both operands
							count_q <= count_q - CW'(2);
							state_q <= CHECK_END;
						end
					endcase
				end
				MUL: begin
					if (mq_q[0]) acc_q <= alu_sum[VW-1:0];
					mcand_q <= {mcand_q[VW-2:0], 1'b0};
					mq_q    <= {1'b0, mq_q[VW-1:1]};
					step_q  <= step_q + SW'(1);
					if (step_q == SW'(VW - 1)) state_q <= PUSH;
				end
				ABS_A: begin
					mq_q    <= a_q[VW-1] ? alu_sum[VW-1:0] : a_q;
					neg_q   <= a_q[VW-1] ^ b_q[VW-1];
					state_q <= ABS_B;
				end
				ABS_B: begin
					if (b_q[VW-1]) b_q <= alu_sum[VW-1:0];
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= DIV;
				end
				DIV: begin
					// restoring step: keep the difference when no borrow
					rem_q   <= alu_carry ? alu_sum[VW:0] : div_x;
					mq_q    <= {mq_q[VW-2:0], alu_carry};
					step_q  <= step_q + SW'(1);
					if (step_q == SW'(VW - 1)) state_q <= FIX;
				end
				FIX: begin
					acc_q   <= neg_q ? alu_sum[VW-1:0] : mq_q;
					state_q <= PUSH;
				end
				PUSH: begin
					count_q <= count_q - CW'(1);
					state_q <= CHECK_END;
				end
				CHECK_END: begin
					state_q <= last_q ? FIN : IDLE;
				end
				FIN: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_value_q <= pfx_pkg::OUT_W'(top_s);
						if (err_q != pfx_pkg::ST_OK) begin
							out_status_q <= err_q;
						end else if (count_q == '0) begin
							out_status_q <= pfx_pkg::ST_EMPTY;
						end else begin
							out_status_q <= pfx_pkg::ST_OK;
						end
						count_q <= '0;
						err_q   <= pfx_pkg::ST_OK;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign value     = out_value_q;
	assign status    = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (count_q == '0) && (err_q == pfx_pkg::ST_OK) && out_valid_q)
		else $error("expression end did not clear the stack");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == pfx_pkg::ST_EMPTY)) |-> (out_value_q == '0))
		else $error("empty stack result with nonzero value");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == DECODE))
		else $error("accepted transaction not decoded");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_we && st_re))
		else $error("stack ram written and read in one cycle");

endmodule

// File: sv/pfx_stack.sv
module pfx_stack #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/tb_postfix_expression_evaluator_core.sv
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator_core;

	localparam int STACK_DEPTH  = 64;
	localparam int VALUE_WIDTH  = 8;
	localparam int RANDOM_ITEMS = 1450;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;

	// operator bytes that the block does not know
	localparam logic [7:0] SYM_AMP      = 8'h26;
	localparam logic [7:0] SYM_NUL      = 8'h00;
	localparam logic [7:0] SYM_ALL_ONES = 8'hFF;

	typedef struct packed {
		logic signed [pfx_pkg::OUT_W-1:0] value;
		pfx_pkg::status_t                 status;
	} result_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_ready;
	logic [7:0]                       symbol    = '0;
	logic                             last      = 1'b0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic signed [pfx_pkg::OUT_W-1:0] value;
	logic [pfx_pkg::STATUS_W-1:0]     status;

	// shadow of the evaluator state
	logic signed [VALUE_WIDTH-1:0] shadow_stack [STACK_DEPTH];
	int                            shadow_depth = 0;
	pfx_pkg::status_t              shadow_error = pfx_pkg::ST_OK;

	result_t pending_results[$];
	int      fail_count    = 0;
	int      symbols_sent  = 0;
	int      results_seen  = 0;
	bit      idle_on       = 1'b1;
	int      hold_request  = 0;

	postfix_expression_evaluator_core #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.symbol   (symbol),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value),
		.status   (status)
	);

	always #5 clk = ~clk;

	function automatic bit is_digit(input logic [7:0] sym);
		return sym >= pfx_pkg::SYM_ZERO && sym <= pfx_pkg::SYM_NINE;
	endfunction

	function automatic void note_error(input pfx_pkg::status_t code);
		if (shadow_error == pfx_pkg::ST_OK)
			shadow_error = code;
	endfunction

	function automatic void push_value(input int x);
		logic [VALUE_WIDTH-1:0] wrapped;
		wrapped = x[VALUE_WIDTH-1:0];
		if (shadow_depth >= STACK_DEPTH) begin
			note_error(pfx_pkg::ST_OVERFLOW);
		end else begin
			shadow_stack[shadow_depth] = wrapped;
			shadow_depth++;
		end
	endfunction

	// applies one accepted symbol and queues the result on an expression end
	function automatic void evaluate_symbol(input logic [7:0] sym, input logic lst);
		int      a;
		int      b;
		result_t res;
		if (is_digit(sym)) begin
			push_value(int'(sym - pfx_pkg::SYM_ZERO));
		end else if (shadow_depth < 2) begin
			note_error(pfx_pkg::ST_UNDERFLOW);
		end else begin
			b = shadow_stack[shadow_depth-1];
			a = shadow_stack[shadow_depth-2];
			shadow_depth -= 2;
			case (sym)
				pfx_pkg::SYM_ADD: push_value(a + b);
				pfx_pkg::SYM_SUB: push_value(a - b);
				pfx_pkg::SYM_MUL: push_value(a * b);
				pfx_pkg::SYM_DIV: begin
					if (b == 0) begin
						note_error(pfx_pkg::ST_DIVZERO);
						push_value(0);
					end else begin
						push_value(a / b);
					end
				end
				default: ;
			endcase
		end
		if (lst) begin
			res.value = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
			if (shadow_error != pfx_pkg::ST_OK)
				res.status = shadow_error;
			else if (shadow_depth == 0)
				res.status = pfx_pkg::ST_EMPTY;
			else
				res.status = pfx_pkg::ST_OK;
			pending_results.push_back(res);
			shadow_depth = 0;
			shadow_error = pfx_pkg::ST_OK;
		end
	endfunction

	// called right after a rising edge; returns at the edge that accepts the transaction
	task automatic send_symbol(input logic [7:0] sym, input logic lst);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		symbol   <= sym;
		last     <= lst;
		do @(posedge clk); while (!in_ready);
		evaluate_symbol(sym, lst);
		symbols_sent++;
	endtask

	task automatic send_expression(input logic [7:0] syms[$]);
		foreach (syms[i])
			send_symbol(syms[i], i == syms.size() - 1);
	endtask

	function automatic logic [7:0] random_digit();
		return pfx_pkg::SYM_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_non_digit();
		logic [7:0] sym;
		do sym = 8'($urandom_range(0, 255)); while (is_digit(sym));
		return sym;
	endfunction

	function automatic logic [7:0] random_operator(input bit allow_unknown);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 5)
			return pfx_pkg::SYM_ADD;
		else if (pick < 10)
			return pfx_pkg::SYM_SUB;
		else if (pick < 15)
			return pfx_pkg::SYM_MUL;
		else if (pick < 19 || !allow_unknown)
			return pfx_pkg::SYM_DIV;
		return random_non_digit();
	endfunction

	// well-formed postfix with random content, closed down to at most one entry
	function automatic void build_expression(input int len, input int max_depth,
	                                         ref logic [7:0] syms[$]);
		int         depth;
		logic [7:0] op;
		depth = 0;
		syms.delete();
		for (int k = 0; k < len; k++) begin
			if (depth < 2 || (depth < max_depth && $urandom_range(0, 1) == 1)) begin
				syms.push_back(random_digit());
				depth++;
			end else begin
				op = random_operator(1'b1);
				syms.push_back(op);
				depth -= is_digit(op) ? 0 :
				         (op == pfx_pkg::SYM_ADD || op == pfx_pkg::SYM_SUB ||
				          op == pfx_pkg::SYM_MUL || op == pfx_pkg::SYM_DIV) ? 1 : 2;
			end
		end
		while (depth > 1) begin
			syms.push_back(random_operator(1'b0));
			depth--;
		end
		if (syms.size() == 0)
			syms.push_back(random_digit());
	endfunction

	task automatic test_directed();
		send_expression('{pfx_pkg::SYM_NINE, pfx_pkg::SYM_NINE, pfx_pkg::SYM_ADD});
		send_expression('{pfx_pkg::SYM_ADD});
		send_expression('{pfx_pkg::SYM_ZERO, pfx_pkg::SYM_NINE, pfx_pkg::SYM_SUB,
		                  pfx_pkg::SYM_ZERO + 8'd2, pfx_pkg::SYM_DIV});
		// 8*8*2 wraps to the most negative value, then divided by minus one
		send_expression('{pfx_pkg::SYM_ZERO + 8'd8, pfx_pkg::SYM_ZERO + 8'd8,
		                  pfx_pkg::SYM_MUL, pfx_pkg::SYM_ZERO + 8'd2, pfx_pkg::SYM_MUL,
		                  pfx_pkg::SYM_ZERO, pfx_pkg::SYM_ZERO + 8'd1, pfx_pkg::SYM_SUB,
		                  pfx_pkg::SYM_DIV});
		send_expression('{pfx_pkg::SYM_ZERO + 8'd5, pfx_pkg::SYM_ZERO, pfx_pkg::SYM_DIV});
		send_expression('{pfx_pkg::SYM_ZERO + 8'd3, pfx_pkg::SYM_ZERO + 8'd4, SYM_ALL_ONES});
		// underflow first, later divide by zero must not replace it
		send_expression('{pfx_pkg::SYM_ZERO + 8'd1, SYM_NUL, pfx_pkg::SYM_ZERO + 8'd2,
		                  pfx_pkg::SYM_ADD, pfx_pkg::SYM_ZERO, pfx_pkg::SYM_DIV});
		send_expression('{pfx_pkg::SYM_ZERO + 8'd6, pfx_pkg::SYM_ZERO + 8'd7, SYM_AMP,
		                  pfx_pkg::SYM_NINE});
	endtask

	task automatic test_stack_limits();
		logic [7:0] syms[$];
		for (int k = 0; k < STACK_DEPTH; k++)
			syms.push_back(random_digit());
		send_expression(syms);
		// two digits beyond full are dropped
		syms.delete();
		for (int k = 0; k < STACK_DEPTH + 2; k++)
			syms.push_back(random_digit());
		syms.push_back(pfx_pkg::SYM_ADD);
		send_expression(syms);
		syms.delete();
		for (int k = 0; k < STACK_DEPTH; k++)
			syms.push_back(random_digit());
		for (int k = 0; k < 8; k++)
			syms.push_back(random_operator(1'b1));
		send_expression(syms);
	endtask

	task automatic test_random_expressions();
		logic [7:0] syms[$];
		int         start_count;
		int         n;
		start_count = symbols_sent;
		n = 0;
		while (symbols_sent - start_count < RANDOM_ITEMS) begin
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			n++;
			if ($urandom_range(0, 6) == 0) begin
				// noise: any bytes at all
				syms.delete();
				repeat ($urandom_range(1, 6))
					syms.push_back(8'($urandom_range(0, 255)));
			end else if ($urandom_range(0, 24) == 0) begin
				build_expression($urandom_range(20, 140), $urandom_range(8, 70), syms);
			end else begin
				build_expression($urandom_range(1, 9), $urandom_range(2, 5), syms);
			end
			send_expression(syms);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		logic [7:0] syms[$];
		idle_on = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (12) begin
			build_expression(3, 2, syms);
			send_expression(syms);
		end
		idle_on = 1'b1;
	endtask

	// receiver: random stall per transaction, plus a long hold when asked
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: value %0d status %0d", value, status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, value);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_limits();
		test_output_backpressure();
		test_random_expressions();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d symbols sent, %0d expression results checked", symbols_sent,
		         results_seen);
		$display("covered all operators, stack full and empty, sticky errors and output hold-off");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
